// File: hw/rtl/itoa_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII converter.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int VALUE_WIDTH    = 64;
    localparam int VALUE_BITS_DEF = 64;
    localparam int FUNC_WIDTH     = 2;
    localparam int CHAR_WIDTH     = 8;
    localparam int NIBBLE_WIDTH   = 4;

    localparam logic [FUNC_WIDTH-1:0] FUNC_UDEC = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_SDEC = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_HEX  = 2'd2;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [NIBBLE_WIDTH-1:0] DEC_BASE = 4'd10;

    // Hand-over from the converter to the character emitter.
    typedef struct packed {
        logic load;
        logic negative;
    } itoa_load_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [NIBBLE_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ch;
        if (d < DEC_BASE)
        begin
            ch = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            ch = CHAR_A + {4'd0, d - DEC_BASE};
        end
        return ch;
    endfunction

endpackage

// File: hw/rtl/itoa_dabble.sv
// Bit-serial binary to BCD (or plain nibble) converter, one input bit per cycle.
`timescale 1ns / 1ps

module itoa_dabble #(
    parameter int VALUE_BITS = 64,
    parameter int DIGITS     = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    decimal,
    input  logic [VALUE_BITS-1:0]   magnitude,
    output logic                    busy,
    output logic                    done,
    output logic [4*DIGITS-1:0]     digits
);
    import itoa_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [4*DIGITS-1:0]   bcd_reg, bcd_next;
    logic [4*DIGITS-1:0]   corr;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  decimal_reg, decimal_next;

    // In decimal mode, add three to every BCD digit of five or more before the shift.
    always_comb
    begin
        logic [NIBBLE_WIDTH-1:0] nib;
        for (int i = 0; i < DIGITS; i++)
        begin
            nib = bcd_reg[4*i +: 4];
            if (decimal_reg && (nib >= 4'd5))
            begin
                nib = nib + 4'd3;
            end
            corr[4*i +: 4] = nib;
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        decimal_next = decimal_reg;
        if (start)
        begin
            bin_next     = magnitude;
            bcd_next     = '0;
            cnt_next     = CW'(VALUE_BITS);
            busy_next    = 1'b1;
            decimal_next = decimal;
        end
        else if (busy_reg)
        begin
            bcd_next = {corr[4*DIGITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        decimal_reg <= decimal_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

// File: hw/rtl/itoa_emit.sv
// Character emitter: drops leading zeros, sends a minus sign first for a negative value, then one ASCII beat per digit.
`timescale 1ns / 1ps

module itoa_emit #(
    parameter int DIGITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itoa_pkg::itoa_load_t          ld,
    input  logic [4*DIGITS-1:0]           digits,
    output logic                          active,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itoa_pkg::CHAR_WIDTH-1:0] m_tdata,
    output logic                          m_tlast
);
    import itoa_pkg::*;

    localparam int RW = $clog2(DIGITS + 1);

    logic [4*DIGITS-1:0]     dig_reg, dig_next;
    logic [RW-1:0]           rem_reg, rem_next;
    logic                    sign_reg, sign_next;
    logic                    started_reg, started_next;
    logic                    active_reg, active_next;
    logic                    oval_reg, oval_next;
    logic [CHAR_WIDTH-1:0]   odata_reg, odata_next;
    logic                    olast_reg, olast_next;
    logic [NIBBLE_WIDTH-1:0] top_dig;
    logic                    advance;

    assign top_dig = dig_reg[4*DIGITS-1 -: 4];
    assign advance = active_reg && (!oval_reg || m_tready);

    always_comb
    begin
        dig_next     = dig_reg;
        rem_next     = rem_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        active_next  = active_reg;
        oval_next    = oval_reg && !m_tready;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        if (ld.load)
        begin
            dig_next     = digits;
            rem_next     = RW'(DIGITS);
            sign_next    = ld.negative;
            started_next = 1'b0;
            active_next  = 1'b1;
        end
        else if (advance)
        begin
            if (sign_reg)
            begin
                oval_next  = 1'b1;
                odata_next = CHAR_MINUS;
                olast_next = 1'b0;
                sign_next  = 1'b0;
            end
            else if (!started_reg && (top_dig == '0) && (rem_reg != RW'(1)))
            begin
                // leading zero: skip without a beat
                dig_next = {dig_reg[4*DIGITS-5:0], 4'd0};
                rem_next = rem_reg - RW'(1);
            end
            else
            begin
                oval_next    = 1'b1;
                odata_next   = digit_char(top_dig);
                olast_next   = (rem_reg == RW'(1));
                dig_next     = {dig_reg[4*DIGITS-5:0], 4'd0};
                rem_next     = rem_reg - RW'(1);
                started_next = 1'b1;
                if (rem_reg == RW'(1))
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            active_reg  <= 1'b0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            rem_reg     <= rem_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            active_reg  <= active_next;
            oval_reg    <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign active   = active_reg;
    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

// File: hw/rtl/integer_to_ascii_digits.sv
// Top level of the integer to ASCII text converter (decimal, signed decimal, hex).
// Flow: the beat is taken, the value is converted bit-serially, the digits are handed over,
//   then leading zeros are skipped and the characters are sent one by one.
// Pacing: a new value is taken only once the previous one has left the converter and the
//   emitter; the bit-serial shift and sink stalls set the rate.
// Reset: rst_n clears all control state at once; no item is in flight afterwards.
`timescale 1ns / 1ps

module integer_to_ascii_digits #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [itoa_pkg::VALUE_WIDTH-1:0]  s_tdata,  // [63:0] value
    input  logic [itoa_pkg::FUNC_WIDTH-1:0]   s_tuser,  // [1:0] func
    // Output side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [itoa_pkg::CHAR_WIDTH-1:0]   m_tdata,  // [7:0] char_code
    output logic                              m_tlast   // last
);
    import itoa_pkg::*;

    // Decimal digits enough for 2^VALUE_BITS - 1; hex never needs more.
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    logic                  accept;
    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  decimal;
    logic                  neg_reg;
    logic                  conv_busy;
    logic                  conv_done;
    logic [4*DIGITS-1:0]   conv_digits;
    logic                  emit_active;
    itoa_load_t            ld;

    // Take a new beat only when both the converter and the emitter are free.
    // The final character may still wait in the output register meanwhile.
    assign s_tready = !conv_busy && !conv_done && !emit_active;
    assign accept   = s_tvalid && s_tready;

    // Bits above VALUE_BITS are ignored. Signed mode negates a negative value;
    // the most negative value comes out as its exact magnitude 2^(VALUE_BITS-1).
    assign raw       = s_tdata[VALUE_BITS-1:0];
    assign negative  = (s_tuser == FUNC_SDEC) && raw[VALUE_BITS-1];
    assign magnitude = negative ? (~raw + VALUE_BITS'(1)) : raw;
    // Unused selector code falls back to unsigned decimal.
    assign decimal   = (s_tuser != FUNC_HEX);

    // Hold the sign until the digits are handed over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else if (accept)
        begin
            neg_reg <= negative;
        end
    end

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .decimal   (decimal),
        .magnitude (magnitude),
        .busy      (conv_busy),
        .done      (conv_done),
        .digits    (conv_digits)
    );

    assign ld.load     = conv_done;
    assign ld.negative = neg_reg;

    itoa_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .digits   (conv_digits),
        .active   (emit_active),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Never take a beat while a conversion runs.
    assert property (@(posedge clk) disable iff (!rst_n) conv_busy |-> !s_tready)
        else $error("input taken during conversion");

    // An accepted beat starts the converter on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> conv_busy)
        else $error("converter did not start");

    // Digits are handed over only to an idle emitter.
    assert property (@(posedge clk) disable iff (!rst_n) conv_done |-> !emit_active)
        else $error("hand-over to a busy emitter");

    // The emitter becomes active right after the hand-over.
    assert property (@(posedge clk) disable iff (!rst_n) conv_done |=> emit_active)
        else $error("emitter did not start");

endmodule
